@@ rtl/cpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cpe_pkg;

    localparam logic [31:0] CPE_MAGIC   = 32'h0145_5043;
    localparam logic [31:0] REG_CODE_PC = 32'h0000_0090;

    localparam logic [7:0] CODE_END  = 8'h00;
    localparam logic [7:0] CODE_BIN  = 8'h01;
    localparam logic [7:0] CODE_REG  = 8'h03;
    localparam logic [7:0] CODE_UNIT = 8'h08;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_CHUNK = 2'd2;
    localparam logic [1:0] ERR_TRUNC = 2'd3;

    localparam int FIELD_BYTES = 4;
    localparam int BYTE_VALUES = 256;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_CODE,
        PH_BIN_ADDR,
        PH_BIN_LEN,
        PH_BIN_DATA,
        PH_REG_CODE,
        PH_REG_VALUE,
        PH_UNIT,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] load_address;
        logic [7:0]  payload_byte;
        logic [31:0] entry_point;
        logic [31:0] text_address;
        logic [31:0] text_size;
        logic        odd_register_seen;
        logic [1:0]  error_code;
    } t_out_item;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

`default_nettype wire

@@ rtl/cpe_parse_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpe_parse_core #(
    parameter int PAD_GRANULE = 2048
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  cpe_pkg::t_in_item      i_item,
    output cpe_pkg::t_push         o_push,
    output cpe_pkg::t_out_item     o_res0,
    output cpe_pkg::t_out_item     o_res1
);
    import cpe_pkg::*;

    localparam int REM_W = (PAD_GRANULE > 1) ? $clog2(PAD_GRANULE) : 1;
    localparam logic [REM_W:0] GRAN = (REM_W + 1)'(PAD_GRANULE);
    localparam logic [REM_W-1:0] WRAP_REM = REM_W'(64'h1_0000_0000 % 64'(PAD_GRANULE));

    function automatic logic [REM_W-1:0] rem_entry(input int unsigned pos,
                                                   input int unsigned val);
        int unsigned w;
        int unsigned acc;
        w = (PAD_GRANULE > 1) ? 1 : 0;
        for (int unsigned k = 0; k < 8 * pos; k++) begin
            w = w * 2;
            if (w >= PAD_GRANULE) begin
                w = w - PAD_GRANULE;
            end
        end
        acc = 0;
        for (int unsigned k = 0; k < val; k++) begin
            acc = acc + w;
            if (acc >= PAD_GRANULE) begin
                acc = acc - PAD_GRANULE;
            end
        end
        return REM_W'(acc);
    endfunction

    logic [REM_W-1:0] rem_tab [FIELD_BYTES][BYTE_VALUES];

    for (genvar gp = 0; gp < FIELD_BYTES; gp++) begin : g_pos
        for (genvar gb = 0; gb < BYTE_VALUES; gb++) begin : g_val
            assign rem_tab[gp][gb] = rem_entry(gp, gb);
        end
    end

    t_phase           r_phase,   n_phase;
    logic [31:0]      r_shift,   n_shift;
    logic [2:0]       r_cnt,     n_cnt;
    logic [31:0]      r_addr,    n_addr;
    logic [31:0]      r_remain,  n_remain;
    logic [31:0]      r_lowest,  n_lowest;
    logic             r_seen,    n_seen;
    logic [31:0]      r_size,    n_size;
    logic [31:0]      r_entry,   n_entry;
    logic             r_odd,     n_odd;
    logic [REM_W-1:0] r_rem,     n_rem;

    logic [1:0]       pos;
    logic [7:0]       b;
    logic [31:0]      shifted;
    logic [2:0]       cnt_inc;
    logic             full4;
    logic             full2;
    logic [REM_W:0]   rem_sum;
    logic [REM_W-1:0] rem_fold;
    logic [32:0]      size_ext;
    logic [REM_W:0]   pad;
    logic [31:0]      remain_dec;
    logic             byte_res;
    logic             trunc;
    t_out_item        res_byte;
    t_out_item        res_trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_shift  <= '0;
            r_cnt    <= '0;
            r_addr   <= '0;
            r_remain <= '0;
            r_lowest <= '0;
            r_seen   <= 1'b0;
            r_size   <= '0;
            r_entry  <= '0;
            r_odd    <= 1'b0;
            r_rem    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_cnt    <= n_cnt;
            r_addr   <= n_addr;
            r_remain <= n_remain;
            r_lowest <= n_lowest;
            r_seen   <= n_seen;
            r_size   <= n_size;
            r_entry  <= n_entry;
            r_odd    <= n_odd;
            r_rem    <= n_rem;
        end
    end

    always_comb begin
        b          = i_item.data_byte;
        pos        = r_cnt[1:0];
        shifted    = r_shift | (32'(b) << {pos, 3'b000});
        cnt_inc    = {1'b0, pos} + 3'd1;
        full4      = (pos == 2'd3);
        full2      = (pos != 2'd0);
        rem_sum    = {1'b0, r_rem} + {1'b0, rem_tab[pos][b]};
        rem_fold   = (rem_sum >= GRAN) ? REM_W'(rem_sum - GRAN) : REM_W'(rem_sum);
        size_ext   = {1'b0, r_size} + {1'b0, shifted};
        pad        = (r_rem == '0) ? '0 : (GRAN - {1'b0, r_rem});
        remain_dec = r_remain - 32'd1;

        n_phase  = r_phase;
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        n_addr   = r_addr;
        n_remain = r_remain;
        n_lowest = r_lowest;
        n_seen   = r_seen;
        n_size   = r_size;
        n_entry  = r_entry;
        n_odd    = r_odd;
        n_rem    = r_rem;

        byte_res  = 1'b0;
        res_byte  = '0;
        res_trunc = '0;
        res_trunc.result_kind = KIND_ERROR;
        res_trunc.error_code  = ERR_TRUNC;

        unique case (r_phase)
            PH_MAGIC: begin
                if (full4) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    if (shifted != CPE_MAGIC) begin
                        byte_res             = 1'b1;
                        res_byte.result_kind = KIND_ERROR;
                        res_byte.error_code  = ERR_MAGIC;
                        n_phase              = PH_ERROR;
                    end else begin
                        n_phase = PH_CODE;
                    end
                end else begin
                    n_shift = shifted;
                    n_cnt   = cnt_inc;
                end
            end
            PH_CODE: begin
                unique case (b)
                    CODE_END: begin
                        byte_res                   = 1'b1;
                        res_byte.result_kind       = KIND_SUMMARY;
                        res_byte.entry_point       = r_entry;
                        res_byte.text_address      = r_seen ? r_lowest : '0;
                        res_byte.text_size         = r_size + 32'(pad);
                        res_byte.odd_register_seen = r_odd;
                        n_phase                    = PH_DONE;
                    end
                    CODE_BIN:  n_phase = PH_BIN_ADDR;
                    CODE_REG:  n_phase = PH_REG_CODE;
                    CODE_UNIT: n_phase = PH_UNIT;
                    default: begin
                        byte_res             = 1'b1;
                        res_byte.result_kind = KIND_ERROR;
                        res_byte.error_code  = ERR_CHUNK;
                        n_phase              = PH_ERROR;
                    end
                endcase
            end
            PH_BIN_ADDR: begin
                if (full4) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    n_addr  = shifted;
                    if (!r_seen || (shifted < r_lowest)) begin
                        n_lowest = shifted;
                    end
                    n_seen  = 1'b1;
                    n_phase = PH_BIN_LEN;
                end else begin
                    n_shift = shifted;
                    n_cnt   = cnt_inc;
                end
            end
            PH_BIN_LEN: begin
                n_rem = rem_fold;
                if (full4) begin
                    n_shift  = '0;
                    n_cnt    = '0;
                    n_remain = shifted;
                    n_size   = size_ext[31:0];
                    if (size_ext[32]) begin
                        n_rem = (rem_fold >= WRAP_REM) ? (rem_fold - WRAP_REM)
                              : REM_W'(GRAN - {1'b0, WRAP_REM} + {1'b0, rem_fold});
                    end
                    n_phase  = (shifted != '0) ? PH_BIN_DATA : PH_CODE;
                end else begin
                    n_shift = shifted;
                    n_cnt   = cnt_inc;
                end
            end
            PH_BIN_DATA: begin
                byte_res              = 1'b1;
                res_byte.result_kind  = KIND_PAYLOAD;
                res_byte.load_address = r_addr;
                res_byte.payload_byte = b;
                n_addr                = r_addr + 32'd1;
                n_remain              = remain_dec;
                if (remain_dec == '0) begin
                    n_phase = PH_CODE;
                end
            end
            PH_REG_CODE: begin
                if (full2) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    if (shifted != REG_CODE_PC) begin
                        n_odd = 1'b1;
                    end
                    n_phase = PH_REG_VALUE;
                end else begin
                    n_shift = shifted;
                    n_cnt   = cnt_inc;
                end
            end
            PH_REG_VALUE: begin
                if (full4) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    n_entry = shifted;
                    n_phase = PH_CODE;
                end else begin
                    n_shift = shifted;
                    n_cnt   = cnt_inc;
                end
            end
            PH_UNIT:  n_phase = PH_CODE;
            PH_DONE:  n_phase = PH_DONE;
            PH_ERROR: n_phase = PH_ERROR;
            default:  n_phase = r_phase;
        endcase

        trunc = i_item.stream_end && (n_phase != PH_DONE) && (n_phase != PH_ERROR);

        if (i_item.stream_end) begin
            n_phase  = PH_MAGIC;
            n_shift  = '0;
            n_cnt    = '0;
            n_addr   = '0;
            n_remain = '0;
            n_lowest = '0;
            n_seen   = 1'b0;
            n_size   = '0;
            n_entry  = '0;
            n_odd    = 1'b0;
            n_rem    = '0;
        end

        o_push.first  = i_accept && (byte_res || trunc);
        o_push.second = i_accept && byte_res && trunc;
        o_res0        = byte_res ? res_byte : res_trunc;
        o_res1        = res_trunc;
    end

endmodule

`default_nettype wire

@@ rtl/cpe_result_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpe_result_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  cpe_pkg::t_push         i_push,
    input  cpe_pkg::t_out_item     i_res0,
    input  cpe_pkg::t_out_item     i_res1,
    output logic                   o_space,
    output logic                   o_valid,
    input  wire                    i_ready,
    output cpe_pkg::t_out_item     o_item
);
    import cpe_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    t_out_item        r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr,  n_wr;
    logic [PTR_W-1:0] r_rd,  n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0] wr_next;
    logic             pop;

    always_comb begin
        pop     = (r_cnt != '0) && i_ready;
        wr_next = r_wr + PTR_W'(1);
        n_wr    = r_wr + PTR_W'(i_push.first) + PTR_W'(i_push.second);
        n_rd    = r_rd + PTR_W'(pop);
        n_cnt   = r_cnt + CNT_W'(i_push.first) + CNT_W'(i_push.second) - CNT_W'(pop);
        o_space = (r_cnt <= CNT_W'(QDEPTH - 2));
        o_valid = (r_cnt != '0);
        o_item  = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.second) begin
            r_mem[wr_next] <= i_res1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cpe_executable_stream_parser.sv @@
// A result is offered in the cycle after the input transfer that causes it,
// when the result queue is empty.
// Throughput: one byte per cycle while input ready is high; the parse state updates in the transfer cycle.
// A stream_end byte that leaves the parse unfinished adds a truncation report, so one
// transfer can yield two results; input ready drops while the four-entry queue holds three or more.
// Reset: synchronous, active low; clears the parse state and empties the result queue.
`timescale 1ns / 1ps
`default_nettype none

module cpe_executable_stream_parser #(
    parameter int PAD_GRANULE = 2048
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  cpe_pkg::t_in_item      i_in_item,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output cpe_pkg::t_out_item     o_out_item
);
    import cpe_pkg::*;

    logic      accept;
    logic      space;
    t_push     push;
    t_out_item res0;
    t_out_item res1;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    cpe_parse_core #(
        .PAD_GRANULE (PAD_GRANULE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    cpe_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ rtl/cpe_stream_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpe_stream_checker (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_in_ready,
    input  cpe_pkg::t_in_item      i_in_item,
    input  wire                    i_out_valid,
    input  wire                    i_out_ready,
    input  cpe_pkg::t_out_item     i_out_item
);
    import cpe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_item))
        else $error("output payload changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    a_trunc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_item.stream_end |=>
            !(i_out_valid && $rose(i_out_valid) && i_out_item.error_code == ERR_TRUNC))
        else $error("truncation report without a final byte");

endmodule

bind cpe_executable_stream_parser cpe_stream_checker u_stream_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire
